[rtl/bmp_pkg.sv]
package bmp_pkg;

  // operand and modulus width
  localparam int unsigned ModW = 31;
  // argument width and saturation limit
  localparam int unsigned ArgW = 12;
  localparam logic [ArgW-1:0] MaxN = ArgW'(4095);
  // bit counter width for the shared multiplier and the exponent scan
  localparam int unsigned CntW = $clog2(ModW);
  // modulus after reset
  localparam logic [ModW-1:0] ModReset = ModW'(1000000007);
  // register file
  localparam int unsigned AddrW = 3;
  localparam logic RegModulus = 1'b0;

  // request to the modular multiplier
  typedef struct packed {
    logic            start;
    logic [ModW-1:0] op_a;
    logic [ModW-1:0] op_b;
  } mm_req_t;

  // answer from the modular multiplier
  typedef struct packed {
    logic            done;
    logic [ModW-1:0] prod;
  } mm_rsp_t;

endpackage

[rtl/binomial_mod_prime_top.sv]
// Binomial coefficient C(n, r) modulo a prime p held in the modulus register
// (address 0, reset 1000000007). One request is worked at a time; in_stall_o
// stays high from acceptance until the result is loaded into the output
// register, which may still be waiting downstream while the next request is
// taken. The answer is 0 when p < 2 or n < r and 1 when r is 0. Otherwise all
// work goes through one shared shift-and-add modular multiplier that retires
// one multiplier bit per cycle. A request then takes n + 62 + 2*w + 2
// products, where w is the number of set bits of p-2: n products for the
// factorial run, 31 squarings plus w products for each of the two
// inversions, and two final products. Arguments above 4095 saturate.
module binomial_mod_prime_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [bmp_pkg::ArgW-1:0]  n_value_i,
  input  logic [bmp_pkg::ArgW-1:0]  r_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [bmp_pkg::ModW-1:0]  binom_result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [bmp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  logic [bmp_pkg::ModW-1:0] mod_q;
  logic                     wr_mod;
  bmp_pkg::mm_req_t         mm_req;
  bmp_pkg::mm_rsp_t         mm_rsp;

  // register access
  assign pready = 1'b1;
  assign wr_mod = psel && penable && pwrite && (paddr[2] == bmp_pkg::RegModulus);
  assign prdata = (paddr[2] == bmp_pkg::RegModulus) ? {1'b0, mod_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= bmp_pkg::ModReset;
    end else if (wr_mod) begin
      mod_q <= pwdata[bmp_pkg::ModW-1:0];
    end
  end

  // sequencer
  bmp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mod_i          (mod_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .n_value_i      (n_value_i),
    .r_value_i      (r_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .binom_result_o (binom_result_o),
    .req_o          (mm_req),
    .rsp_i          (mm_rsp)
  );

  // shared modular multiplier
  bmp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mod_i  (mod_q),
    .req_i  (mm_req),
    .rsp_o  (mm_rsp)
  );

endmodule

[rtl/bmp_mulmod.sv]
module bmp_mulmod (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bmp_pkg::ModW-1:0] mod_i,
  input  bmp_pkg::mm_req_t         req_i,
  output bmp_pkg::mm_rsp_t         rsp_o
);

  logic [bmp_pkg::ModW-1:0] a_q;
  logic [bmp_pkg::ModW-1:0] b_q;
  logic [bmp_pkg::ModW-1:0] acc_q;
  logic [bmp_pkg::CntW-1:0] cnt_q;
  logic                     busy_q;
  logic                     done_q;

  logic [bmp_pkg::ModW+1:0] sum;
  logic [bmp_pkg::ModW+1:0] p_ext;
  logic [bmp_pkg::ModW+1:0] p2_ext;
  logic [bmp_pkg::ModW+1:0] red;

  // one bit of b per cycle, msb first: acc = 2*acc + bit*a, kept below p
  assign p_ext  = {2'b00, mod_i};
  assign p2_ext = {1'b0, mod_i, 1'b0};
  assign sum    = {1'b0, acc_q, 1'b0} + {2'b00, (b_q[bmp_pkg::ModW-1] ? a_q : '0)};

  // sum stays below 3p, so at most two subtractions of p
  always_comb begin
    if (sum >= p2_ext) begin
      red = sum - p2_ext;
    end else if (sum >= p_ext) begin
      red = sum - p_ext;
    end else begin
      red = sum;
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !req_i.start &&
                (cnt_q == bmp_pkg::CntW'(bmp_pkg::ModW - 1));
      if (req_i.start) begin
        a_q    <= req_i.op_a;
        b_q    <= req_i.op_b;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= red[bmp_pkg::ModW-1:0];
        b_q   <= {b_q[bmp_pkg::ModW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == bmp_pkg::CntW'(bmp_pkg::ModW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

[rtl/bmp_ctrl.sv]
module bmp_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [bmp_pkg::ModW-1:0] mod_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [bmp_pkg::ArgW-1:0] n_value_i,
  input  logic [bmp_pkg::ArgW-1:0] r_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [bmp_pkg::ModW-1:0] binom_result_o,
  output bmp_pkg::mm_req_t         req_o,
  input  bmp_pkg::mm_rsp_t         rsp_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FACT,
    S_PSET,
    S_POW,
    S_FINAL,
    S_HOLD
  } state_e;

  state_e                   state_q;
  logic                     pend_q;
  logic                     pass_q;
  logic                     step_q;
  logic [bmp_pkg::ArgW-1:0] n_q;
  logic [bmp_pkg::ArgW-1:0] r_q;
  logic [bmp_pkg::ArgW-1:0] nr_q;
  logic [bmp_pkg::ArgW-1:0] i_q;
  logic [bmp_pkg::ArgW-1:0] im_q;
  logic [bmp_pkg::ModW-1:0] f_q;
  logic [bmp_pkg::ModW-1:0] fr_q;
  logic [bmp_pkg::ModW-1:0] fnr_q;
  logic [bmp_pkg::ModW-1:0] acc_q;
  logic [bmp_pkg::ModW-1:0] base_q;
  logic [bmp_pkg::ModW-1:0] exp_q;
  logic [bmp_pkg::CntW-1:0] cnt_q;
  logic [bmp_pkg::ModW-1:0] res_q;
  logic                     out_valid_q;
  logic [bmp_pkg::ModW-1:0] out_q;
  bmp_pkg::mm_req_t         req_q;

  logic [bmp_pkg::ArgW-1:0] n_sat;
  logic [bmp_pkg::ArgW-1:0] r_sat;
  logic [bmp_pkg::ArgW:0]   im_inc;
  logic [bmp_pkg::ArgW-1:0] im_next;
  logic                     issue;

  // saturate arguments to the supported maximum
  assign n_sat = (n_value_i > bmp_pkg::MaxN) ? bmp_pkg::MaxN : n_value_i;
  assign r_sat = (r_value_i > bmp_pkg::MaxN) ? bmp_pkg::MaxN : r_value_i;

  // running i mod p for the factorial factor
  assign im_inc  = {1'b0, im_q} + 1'b1;
  assign im_next = (bmp_pkg::ModW'(im_inc) == mod_i) ? '0 : im_inc[bmp_pkg::ArgW-1:0];

  // a product is started whenever no product is outstanding and one is due
  assign issue = !pend_q && ((state_q inside {S_FACT, S_FINAL}) ||
                             (state_q == S_POW && (step_q || exp_q[0])));

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign binom_result_o = out_q;
  assign req_o          = req_q;

  // sequencer: trivial cases, factorial loop, two fermat inversions, two final products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      pass_q      <= 1'b0;
      step_q      <= 1'b0;
      n_q         <= '0;
      r_q         <= '0;
      nr_q        <= '0;
      i_q         <= '0;
      im_q        <= '0;
      f_q         <= '0;
      fr_q        <= '0;
      fnr_q       <= '0;
      acc_q       <= '0;
      base_q      <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      req_q       <= '0;
    end else begin
      req_q.start <= issue;
      // load a finished result, or let downstream take the current one
      if (state_q == S_HOLD && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
        out_q       <= res_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            n_q  <= n_sat;
            r_q  <= r_sat;
            nr_q <= n_sat - r_sat;
            if (mod_i < bmp_pkg::ModW'(2)) begin
              res_q   <= '0;
              state_q <= S_HOLD;
            end else if (n_sat < r_sat) begin
              res_q   <= '0;
              state_q <= S_HOLD;
            end else if (r_sat == '0) begin
              res_q   <= bmp_pkg::ModW'(1);
              state_q <= S_HOLD;
            end else begin
              f_q     <= bmp_pkg::ModW'(1);
              fr_q    <= bmp_pkg::ModW'(1);
              fnr_q   <= bmp_pkg::ModW'(1);
              i_q     <= bmp_pkg::ArgW'(1);
              im_q    <= bmp_pkg::ArgW'(1);
              pend_q  <= 1'b0;
              pass_q  <= 1'b0;
              state_q <= S_FACT;
            end
          end
        end
        S_FACT: begin
          if (!pend_q) begin
            req_q.op_a  <= f_q;
            req_q.op_b  <= bmp_pkg::ModW'(im_q);
            pend_q      <= 1'b1;
          end else if (rsp_i.done) begin
            pend_q <= 1'b0;
            f_q    <= rsp_i.prod;
            if (i_q == r_q) begin
              fr_q <= rsp_i.prod;
            end
            if (i_q == nr_q) begin
              fnr_q <= rsp_i.prod;
            end
            if (i_q == n_q) begin
              state_q <= S_PSET;
            end else begin
              i_q  <= i_q + 1'b1;
              im_q <= im_next;
            end
          end
        end
        S_PSET: begin
          base_q  <= pass_q ? fnr_q : fr_q;
          acc_q   <= bmp_pkg::ModW'(1);
          exp_q   <= mod_i - bmp_pkg::ModW'(2);
          cnt_q   <= '0;
          step_q  <= 1'b0;
          pend_q  <= 1'b0;
          state_q <= S_POW;
        end
        S_POW: begin
          if (!pend_q) begin
            if (!step_q) begin
              // multiply into the accumulator only for a set exponent bit
              if (exp_q[0]) begin
                req_q.op_a  <= acc_q;
                req_q.op_b  <= base_q;
                pend_q      <= 1'b1;
              end else begin
                step_q <= 1'b1;
              end
            end else begin
              req_q.op_a  <= base_q;
              req_q.op_b  <= base_q;
              pend_q      <= 1'b1;
            end
          end else if (rsp_i.done) begin
            pend_q <= 1'b0;
            if (!step_q) begin
              acc_q  <= rsp_i.prod;
              step_q <= 1'b1;
            end else begin
              base_q <= rsp_i.prod;
              exp_q  <= exp_q >> 1;
              step_q <= 1'b0;
              cnt_q  <= cnt_q + 1'b1;
              if (cnt_q == bmp_pkg::CntW'(bmp_pkg::ModW - 1)) begin
                state_q <= S_FINAL;
              end
            end
          end
        end
        S_FINAL: begin
          if (!pend_q) begin
            req_q.op_a  <= f_q;
            req_q.op_b  <= acc_q;
            pend_q      <= 1'b1;
          end else if (rsp_i.done) begin
            pend_q <= 1'b0;
            if (!pass_q) begin
              f_q     <= rsp_i.prod;
              pass_q  <= 1'b1;
              state_q <= S_PSET;
            end else begin
              res_q   <= rsp_i.prod;
              state_q <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/bmp_checker.sv]
module bmp_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [bmp_pkg::ModW-1:0] binom_result_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(binom_result_o))
    else $error("result changed while stalled");

  // an accepted request makes the block busy
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while not busy afterwards");

  // a new result only comes out of a busy period
  a_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in progress");

endmodule

bind binomial_mod_prime_top bmp_checker u_bmp_checker (.*);
